// ----- sv/cpm_pkg.sv -----
package cpm_pkg;

    localparam int POS_W       = 16;
    localparam int PERIOD_W    = 17;
    localparam int COUNT_W     = 11;
    localparam int SUM_W       = 27;
    localparam int DIFF_W      = 18;
    localparam int MAX_SAMPLES = 1024;
    localparam int M_W         = SUM_W + 2;

    localparam int DIVIDEND_W  = SUM_W;
    localparam int DIVISOR_W   = PERIOD_W;
    localparam int STEP_W      = $clog2(DIVIDEND_W);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(16384);
    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = PERIOD_W'(2);
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = PERIOD_W'(65536);

    localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W+1)'((2 ** (SUM_W - 1)) - 1);
    localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W+1)'(2 ** (SUM_W - 1));

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } div_rsp_t;

endpackage

// ----- sv/cpm_div.sv -----
module cpm_div
    import cpm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  trial;

    // One quotient bit per cycle, restoring form.
    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DIVISOR_W+1])
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- sv/circular_position_mean.sv -----
// Circular mean of a set of wrap-around positions. The first sample of a set is the
// reference; each of the first 1024 samples adds its shortest wrapped distance from
// it to a saturating sum, later ones only set count_overflow, and the item flagged
// last closes the set with one result. An item that does not close a set is first
// taken and its wrapped difference formed, then that is added into the sum. The
// item that closes a set then goes through two passes of one shared restoring
// divider (issue, load, 27 steps of one quotient bit per cycle, collect), first for
// the sum over the count, then for the floor modulo by the period, and then loads
// the output register once that is free. The result waits in that register, so the
// next set may start while it is still stalled. The period is clamped into
// [2, 65536].
module circular_position_mean
    import cpm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [PERIOD_W-1:0] cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [POS_W-1:0]    sample,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [POS_W-1:0]    mean_position,
    output logic [COUNT_W-1:0]  samples_used,
    output logic                count_overflow
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_QSTART,
        S_QUO,
        S_MSTART,
        S_MOD,
        S_OUT
    } state_t;

    state_t                      state_reg, state_next;
    logic [PERIOD_W-1:0]         period_reg, period_next;
    logic [POS_W-1:0]            reference_reg, reference_next;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;
    logic [COUNT_W-1:0]          count_reg, count_next;
    logic                        ovf_reg, ovf_next;
    logic signed [DIFF_W-1:0]    diff_reg, diff_next;
    logic                        use_reg, use_next;
    logic                        last_reg, last_next;
    logic                        qneg_reg, qneg_next;
    logic signed [M_W-1:0]       m_reg, m_next;
    div_req_t                    req_reg, req_next;
    logic                        out_valid_reg, out_valid_next;
    logic [POS_W-1:0]            mean_reg, mean_next;
    logic [COUNT_W-1:0]          used_reg, used_next;
    logic                        flag_reg, flag_next;

    div_rsp_t                    div_rsp;

    logic [PERIOD_W-1:0]         period_eff;
    logic [POS_W-1:0]            ref_sel;
    logic signed [DIFF_W:0]      d_raw;
    logic signed [DIFF_W:0]      d_half;
    logic signed [DIFF_W:0]      d_per;
    logic signed [DIFF_W:0]      d_wrap;
    logic signed [SUM_W:0]       sum_wide;
    logic signed [SUM_W:0]       q_signed;
    logic [PERIOD_W-1:0]         rem_fix;

    cpm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_reg),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        if (period_reg < PERIOD_MIN)
        begin
            period_eff = PERIOD_MIN;
        end
        else if (period_reg > PERIOD_MAX)
        begin
            period_eff = PERIOD_MAX;
        end
        else
        begin
            period_eff = period_reg;
        end
    end

    // Shortest wrapped difference of the incoming sample from the reference.
    always_comb
    begin
        ref_sel = (count_reg == '0) ? sample : reference_reg;
        d_raw   = $signed({3'b000, sample}) - $signed({3'b000, ref_sel});
        d_half  = $signed({3'b000, period_eff[PERIOD_W-1:1]});
        d_per   = $signed({2'b00, period_eff});
        if (d_raw > d_half)
        begin
            d_wrap = d_raw - d_per;
        end
        else if (d_raw <= -d_half)
        begin
            d_wrap = d_raw + d_per;
        end
        else
        begin
            d_wrap = d_raw;
        end
    end

    assign sum_wide = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(diff_reg);
    assign q_signed = qneg_reg ? -$signed({1'b0, div_rsp.quotient})
                               : $signed({1'b0, div_rsp.quotient});
    assign rem_fix  = (m_reg[M_W-1] && (div_rsp.remainder != '0))
                      ? period_eff - div_rsp.remainder : div_rsp.remainder;

    always_comb
    begin
        state_next     = state_reg;
        period_next    = cfg_wr_en ? cfg_wr_data : period_reg;
        reference_next = reference_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        diff_next      = diff_reg;
        use_next       = use_reg;
        last_next      = last_reg;
        qneg_next      = qneg_reg;
        m_next         = m_reg;
        req_next       = req_reg;
        req_next.start = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        mean_next      = mean_reg;
        used_next      = used_reg;
        flag_next      = flag_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    reference_next = ref_sel;
                    diff_next      = d_wrap[DIFF_W-1:0];
                    use_next       = count_reg < COUNT_W'(MAX_SAMPLES);
                    last_next      = last;
                    state_next     = S_ACC;
                end
            end
            S_ACC:
            begin
                if (use_reg)
                begin
                    if (sum_wide > SUM_MAX)
                    begin
                        sum_next = SUM_MAX[SUM_W-1:0];
                    end
                    else if (sum_wide < SUM_MIN)
                    begin
                        sum_next = SUM_MIN[SUM_W-1:0];
                    end
                    else
                    begin
                        sum_next = sum_wide[SUM_W-1:0];
                    end
                    count_next = count_reg + COUNT_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                state_next = last_reg ? S_QSTART : S_IDLE;
            end
            S_QSTART:
            begin
                qneg_next         = sum_reg[SUM_W-1];
                req_next.start    = 1'b1;
                req_next.dividend = sum_reg[SUM_W-1] ? DIVIDEND_W'(-sum_reg)
                                                     : DIVIDEND_W'(sum_reg);
                req_next.divisor  = DIVISOR_W'(count_reg);
                state_next        = S_QUO;
            end
            S_QUO:
            begin
                if (div_rsp.done)
                begin
                    // An empty set cannot reach here, but it would average to the reference.
                    if (count_reg == '0)
                    begin
                        m_next = M_W'($signed({1'b0, reference_reg}));
                    end
                    else
                    begin
                        m_next = M_W'($signed({1'b0, reference_reg})) + M_W'(q_signed);
                    end
                    state_next = S_MSTART;
                end
            end
            S_MSTART:
            begin
                req_next.start    = 1'b1;
                req_next.dividend = m_reg[M_W-1] ? DIVIDEND_W'(-m_reg)
                                                 : DIVIDEND_W'(m_reg);
                req_next.divisor  = period_eff;
                state_next        = S_MOD;
            end
            S_MOD:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // The divider is idle here, so its remainder still holds the mean.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    mean_next      = rem_fix[POS_W-1:0];
                    used_next      = count_reg;
                    flag_next      = ovf_reg;
                    reference_next = '0;
                    sum_next       = '0;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            period_reg    <= PERIOD_RESET;
            reference_reg <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            req_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            period_reg    <= period_next;
            reference_reg <= reference_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            req_reg       <= req_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg         <= diff_next;
        use_reg          <= use_next;
        last_reg         <= last_next;
        qneg_reg         <= qneg_next;
        m_reg            <= m_next;
        mean_reg         <= mean_next;
        used_reg         <= used_next;
        flag_reg         <= flag_next;
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign mean_position  = mean_reg;
    assign samples_used   = used_reg;
    assign count_overflow = flag_reg;

endmodule

// ----- sv/cpm_checker.sv -----
module cpm_checker
    import cpm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               last,
    input logic               out_valid,
    input logic               out_stall,
    input logic [POS_W-1:0]   mean_position,
    input logic [COUNT_W-1:0] samples_used,
    input logic               count_overflow
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mean_position)
            && $stable(samples_used) && $stable(count_overflow))
        else $error("stalled result changed");

    // Every taken item keeps the block busy for the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted on back-to-back cycles");

    // A set always holds at least one sample and never more than the cap.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (samples_used != '0) && (samples_used <= COUNT_W'(MAX_SAMPLES)))
        else $error("sample count out of range");

    // Samples are only dropped once the cap was reached.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && count_overflow |-> samples_used == COUNT_W'(MAX_SAMPLES))
        else $error("overflow flagged below the cap");

    // No new result appears straight after the item that closes a set is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last |=> !out_valid || out_stall || $past(out_valid))
        else $error("result appeared too early");

endmodule

bind circular_position_mean cpm_checker u_cpm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .last           (last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .mean_position  (mean_position),
    .samples_used   (samples_used),
    .count_overflow (count_overflow)
);
